// ----- hdl/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared codes, types and defaults of the pixel store with box tracking.
// ----------------------------------------------------------------------------
package pst_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;

	localparam int PIX_W = 32;
	localparam int CNT_W = 17;
	localparam int CFG_W = 9;

	localparam logic [CNT_W-1:0] COUNT_LIMIT = 17'd65536;

	localparam logic [2:0] FN_PIXEL  = 3'd0;
	localparam logic [2:0] FN_RED    = 3'd1;
	localparam logic [2:0] FN_GREEN  = 3'd2;
	localparam logic [2:0] FN_BLUE   = 3'd3;
	localparam logic [2:0] FN_ALPHA  = 3'd4;
	localparam logic [2:0] FN_READ   = 3'd5;
	localparam logic [2:0] FN_FILL   = 3'd6;
	localparam logic [2:0] FN_UNUSED = 3'd7;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_TRACK  = 2'd2;
	localparam logic [1:0] REG_EBLACK = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_FILL,
		ST_SCAN
	} pst_state_t;

endpackage

// ----- hdl/pst_mem.sv -----
// ----------------------------------------------------------------------------
// pst_mem
// Simple dual-port pixel memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pst_mem #(
	parameter int DEPTH = pst_pkg::DEF_MAX_WIDTH * pst_pkg::DEF_MAX_HEIGHT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [pst_pkg::PIX_W-1:0]  wdata,
	input  logic [AW-1:0]              raddr,
	output logic [pst_pkg::PIX_W-1:0]  rdata
);

	logic [pst_pkg::PIX_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/pixel_store_bbox_tracker.sv -----
// ----------------------------------------------------------------------------
// pixel_store_bbox_tracker
// RGBA canvas store with opaque pixel count and bounding box of opaque pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken at a clock edge with start high
//   and busy low. Each command gives one result, shown for one cycle with
//   done high; the receiver cannot stall, so results are never held back.
//   Configuration: APB-style port, registers at byte offsets 0, 4, 8, 12
//   (width, height, track_box, empty_black); pready is always high. Write
//   registers only while busy is low.
// Timing:
//   Pixel read and write commands first read the memory word, then modify it
//   and write it back in the RMW state. done rises in the cycle after that.
//   Fill is one pipelined read-compare-write sweep over the memory port pair.
//   A write that clears a pixel with box update on adds a rescan of the old
//   box (or canvas), one pixel per cycle.
// Reset:
//   After reset a clearing pass writes zero to all MAX_WIDTH*MAX_HEIGHT
//   words, one per cycle; busy stays high until it ends. Config writes are
//   taken during it.
// ----------------------------------------------------------------------------
module pixel_store_bbox_tracker #(
	parameter int MAX_WIDTH  = pst_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = pst_pkg::DEF_MAX_HEIGHT,
	localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
	localparam int BW    = ((XW > YW) ? XW : YW) + 1,
	localparam int WW    = $clog2(MAX_WIDTH + 1),
	localparam int HW    = $clog2(MAX_HEIGHT + 1),
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW    = $clog2(DEPTH + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [2:0]           func,
	input  logic signed [15:0]   x,
	input  logic signed [15:0]   y,
	input  logic [7:0]           red,
	input  logic [7:0]           green,
	input  logic [7:0]           blue,
	input  logic [7:0]           alpha,
	input  logic                 update_bbox,
	output logic                 done,
	output logic [7:0]           read_red,
	output logic [7:0]           read_green,
	output logic [7:0]           read_blue,
	output logic [7:0]           read_alpha,
	output logic                 modified,
	output logic                 out_of_range,
	output logic [16:0]          opaque_total,
	output logic signed [BW-1:0] box_left,
	output logic signed [BW-1:0] box_top,
	output logic signed [BW-1:0] box_right,
	output logic signed [BW-1:0] box_bottom,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam logic signed [BW-1:0] NONE = '1;

	pst_pkg::pst_state_t state_q, state_d;

	logic [pst_pkg::CFG_W-1:0] wid_q, hgt_q;
	logic                      track_q, eblack_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;

	logic [pst_pkg::CNT_W-1:0] count_q;
	logic signed [BW-1:0]      left_q, top_q, right_q, bottom_q;

	logic                      we;
	logic [AW-1:0]             waddr, raddr;
	logic [pst_pkg::PIX_W-1:0] wdata, rdata;

	logic [AW-1:0] clr_q;

	logic [2:0]                func_q;
	logic [XW-1:0]             x_q;
	logic [YW-1:0]             y_q;
	logic [pst_pkg::PIX_W-1:0] colour_q, fillc_q;
	logic                      upd_q, cmd_oor_q;
	logic [AW-1:0]             addr_q;

	logic       done_q, mod_q, res_oor_q;
	logic [31:0] rd_q;

	logic [NW-1:0] fcnt_q, filln_q;
	logic          fv_s1;
	logic [AW-1:0] fa_s1;

	logic [XW-1:0] cx_q, ex_q, cx_s1;
	logic [YW-1:0] cy_q, sy_q, ey_q, cy_s1;
	logic          sc_issue_q, sv_s1, inb_s1, found_q;
	logic signed [BW-1:0] fx_q, fy_q, l_q, t_q, r_q, b_q;

	logic                      in_oor;
	logic [31:0]               acc_prod, scan_prod;
	logic [pst_pkg::PIX_W-1:0] colour_in, nw;
	logic [7:0]                pa, na;
	logic                      blank, rmw_write, need_scan, fill_end, scan_end, hit;
	logic signed [BW-1:0]      gx, gy, sx_s, sy_s;

	// configuration
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wid_q    <= 9'd256;
			hgt_q    <= 9'd256;
			track_q  <= 1'b1;
			eblack_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				pst_pkg::REG_WIDTH:  wid_q    <= pwdata[pst_pkg::CFG_W-1:0];
				pst_pkg::REG_HEIGHT: hgt_q    <= pwdata[pst_pkg::CFG_W-1:0];
				pst_pkg::REG_TRACK:  track_q  <= pwdata[0];
				pst_pkg::REG_EBLACK: eblack_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			pst_pkg::REG_WIDTH:  prdata = 32'(wid_q);
			pst_pkg::REG_HEIGHT: prdata = 32'(hgt_q);
			pst_pkg::REG_TRACK:  prdata = 32'(track_q);
			pst_pkg::REG_EBLACK: prdata = 32'(eblack_q);
			default:             prdata = '0;
		endcase
	end

	always_comb begin
		if (wid_q == '0) w_eff = WW'(1);
		else if (32'(wid_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(wid_q);
		if (hgt_q == '0) h_eff = HW'(1);
		else if (32'(hgt_q) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
		else h_eff = HW'(hgt_q);
	end

	// command decode
	assign colour_in = {alpha, blue, green, red};
	assign in_oor    = x[15] || y[15] || (x >= 16'(w_eff)) || (y >= 16'(h_eff));
	assign acc_prod  = 32'(y[YW-1:0]) * 32'(w_eff) + 32'(x[XW-1:0]);
	assign scan_prod = 32'(cy_q) * 32'(w_eff) + 32'(cx_q);

	// read-modify-write
	assign pa    = rdata[31:24];
	assign blank = eblack_q && (pa == 8'd0);

	always_comb begin
		nw = rdata;
		case (func_q)
			pst_pkg::FN_PIXEL:
				nw = (eblack_q && colour_q[31:24] == 8'd0) ? '0 : colour_q;
			pst_pkg::FN_RED:
				nw = {rdata[31:8], blank ? 8'd0 : colour_q[7:0]};
			pst_pkg::FN_GREEN:
				nw = {rdata[31:16], blank ? 8'd0 : colour_q[15:8], rdata[7:0]};
			pst_pkg::FN_BLUE:
				nw = {rdata[31:24], blank ? 8'd0 : colour_q[23:16], rdata[15:0]};
			pst_pkg::FN_ALPHA:
				nw = (eblack_q && colour_q[31:24] == 8'd0) ? '0 :
					{colour_q[31:24], rdata[23:0]};
			default: nw = rdata;
		endcase
	end

	assign na        = nw[31:24];
	assign rmw_write = (func_q < pst_pkg::FN_READ) && !cmd_oor_q && (nw != rdata);
	assign need_scan = rmw_write && (na == 8'd0) && (pa != 8'd0) && track_q && upd_q;
	assign gx        = BW'(x_q);
	assign gy        = BW'(y_q);
	assign fill_end  = (fcnt_q == filln_q) && !fv_s1;
	assign scan_end  = !sc_issue_q && !sv_s1;
	assign hit       = sv_s1 && inb_s1 && (rdata[31:24] != 8'd0);
	assign sx_s      = BW'(cx_s1);
	assign sy_s      = BW'(cy_s1);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pst_pkg::ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = pst_pkg::ST_IDLE;
			pst_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (func == pst_pkg::FN_FILL) ? pst_pkg::ST_FILL
						: pst_pkg::ST_RMW;
				end
			end
			pst_pkg::ST_RMW:  state_d = need_scan ? pst_pkg::ST_SCAN : pst_pkg::ST_IDLE;
			pst_pkg::ST_FILL: if (fill_end) state_d = pst_pkg::ST_IDLE;
			pst_pkg::ST_SCAN: if (scan_end) state_d = pst_pkg::ST_IDLE;
			default:          state_d = pst_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		busy  = 1'b1;
		we    = 1'b0;
		waddr = addr_q;
		wdata = nw;
		raddr = '0;
		unique case (state_q)
			pst_pkg::ST_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			pst_pkg::ST_IDLE: begin
				busy  = 1'b0;
				raddr = acc_prod[AW-1:0];
			end
			pst_pkg::ST_RMW:  we = rmw_write;
			pst_pkg::ST_FILL: begin
				we    = fv_s1;
				waddr = fa_s1;
				wdata = fillc_q;
				raddr = fcnt_q[AW-1:0];
			end
			pst_pkg::ST_SCAN: raddr = scan_prod[AW-1:0];
			default: ;
		endcase
	end

	pst_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// command payload
	always_ff @(posedge clk) begin
		if (state_q == pst_pkg::ST_IDLE && start) begin
			func_q    <= func;
			x_q       <= x[XW-1:0];
			y_q       <= y[YW-1:0];
			colour_q  <= colour_in;
			fillc_q   <= (eblack_q && alpha == 8'd0) ? '0 : colour_in;
			upd_q     <= update_bbox;
			cmd_oor_q <= (func <= pst_pkg::FN_READ) && in_oor;
			addr_q    <= acc_prod[AW-1:0];
			filln_q   <= NW'(32'(w_eff) * 32'(h_eff));
		end
		fa_s1  <= fcnt_q[AW-1:0];
		cx_s1  <= cx_q;
		cy_s1  <= cy_q;
		inb_s1 <= (32'(cx_q) < 32'(w_eff)) && (32'(cy_q) < 32'(h_eff));
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == pst_pkg::ST_RMW) && !need_scan)
				|| ((state_q == pst_pkg::ST_FILL) && fill_end)
				|| ((state_q == pst_pkg::ST_SCAN) && scan_end);
		end
	end

	// control and tracked state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pst_pkg::ST_CLEAR;
			clr_q      <= '0;
			count_q    <= '0;
			left_q     <= NONE;
			top_q      <= NONE;
			right_q    <= NONE;
			bottom_q   <= NONE;
			mod_q      <= 1'b0;
			res_oor_q  <= 1'b0;
			rd_q       <= '0;
			fcnt_q     <= '0;
			fv_s1      <= 1'b0;
			sc_issue_q <= 1'b0;
			sv_s1      <= 1'b0;
			found_q    <= 1'b0;
			cx_q       <= '0;
			cy_q       <= '0;
			sy_q       <= '0;
			ex_q       <= '0;
			ey_q       <= '0;
			fx_q       <= NONE;
			fy_q       <= NONE;
			l_q        <= NONE;
			t_q        <= NONE;
			r_q        <= NONE;
			b_q        <= NONE;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				pst_pkg::ST_CLEAR: clr_q <= clr_q + AW'(1);
				pst_pkg::ST_IDLE: begin
					fcnt_q <= '0;
					fv_s1  <= 1'b0;
					mod_q  <= 1'b0;
				end
				pst_pkg::ST_RMW: begin
					rd_q      <= (func_q == pst_pkg::FN_READ && !cmd_oor_q) ? rdata : '0;
					mod_q     <= rmw_write;
					res_oor_q <= cmd_oor_q;
					if (rmw_write && na == 8'd0 && pa != 8'd0) begin
						if (count_q != '0) count_q <= count_q - 1'b1;
					end else if (rmw_write && na != 8'd0 && pa == 8'd0) begin
						if (count_q < pst_pkg::COUNT_LIMIT) count_q <= count_q + 1'b1;
						if (track_q && upd_q) begin
							if (left_q == NONE) begin
								left_q   <= gx;
								right_q  <= gx;
								top_q    <= gy;
								bottom_q <= gy;
							end else begin
								if (gx < left_q) left_q <= gx;
								else if (gx > right_q) right_q <= gx;
								if (gy < top_q) top_q <= gy;
								else if (gy > bottom_q) bottom_q <= gy;
							end
						end
					end
					if (need_scan) begin
						sc_issue_q <= 1'b1;
						sv_s1      <= 1'b0;
						found_q    <= 1'b0;
						if (left_q == NONE) begin
							cx_q <= '0;
							cy_q <= '0;
							sy_q <= '0;
							ex_q <= XW'(w_eff - 1'b1);
							ey_q <= YW'(h_eff - 1'b1);
						end else begin
							cx_q <= left_q[XW-1:0];
							cy_q <= top_q[YW-1:0];
							sy_q <= top_q[YW-1:0];
							ex_q <= right_q[XW-1:0];
							ey_q <= bottom_q[YW-1:0];
						end
					end
				end
				pst_pkg::ST_FILL: begin
					if (fcnt_q != filln_q) begin
						fcnt_q <= fcnt_q + 1'b1;
						fv_s1  <= 1'b1;
					end else begin
						fv_s1 <= 1'b0;
					end
					if (fv_s1 && rdata != fillc_q) mod_q <= 1'b1;
					if (fill_end) begin
						rd_q      <= '0;
						res_oor_q <= 1'b0;
						if (fillc_q[31:24] != 8'd0 || colour_q[31:24] != 8'd0) begin
							count_q <= pst_pkg::CNT_W'(filln_q);
							if (track_q) begin
								left_q   <= '0;
								top_q    <= '0;
								right_q  <= BW'(w_eff - 1'b1);
								bottom_q <= BW'(h_eff - 1'b1);
							end
						end else begin
							count_q <= '0;
							if (track_q) begin
								left_q   <= NONE;
								top_q    <= NONE;
								right_q  <= NONE;
								bottom_q <= NONE;
							end
						end
					end
				end
				pst_pkg::ST_SCAN: begin
					sv_s1 <= sc_issue_q;
					if (sc_issue_q) begin
						if (cy_q == ey_q) begin
							cy_q <= sy_q;
							if (cx_q == ex_q) sc_issue_q <= 1'b0;
							else cx_q <= cx_q + 1'b1;
						end else begin
							cy_q <= cy_q + 1'b1;
						end
					end
					if (hit) begin
						found_q <= 1'b1;
						r_q     <= sx_s;
						if (!found_q) begin
							fx_q <= sx_s;
							fy_q <= sy_s;
							l_q  <= sx_s;
							t_q  <= sy_s;
							b_q  <= sy_s;
						end else begin
							if (sy_s < t_q) t_q <= sy_s;
							if (sy_s > b_q) b_q <= sy_s;
						end
					end
					if (scan_end) begin
						if (!found_q) begin
							left_q   <= NONE;
							top_q    <= NONE;
							right_q  <= NONE;
							bottom_q <= NONE;
						end else if (count_q == pst_pkg::CNT_W'(1)) begin
							left_q   <= fx_q;
							top_q    <= fy_q;
							right_q  <= fx_q;
							bottom_q <= fy_q;
						end else begin
							left_q   <= l_q;
							top_q    <= t_q;
							right_q  <= r_q;
							bottom_q <= b_q;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign done         = done_q;
	assign read_red     = rd_q[7:0];
	assign read_green   = rd_q[15:8];
	assign read_blue    = rd_q[23:16];
	assign read_alpha   = rd_q[31:24];
	assign modified     = mod_q;
	assign out_of_range = res_oor_q;
	assign opaque_total = count_q;
	assign box_left     = left_q;
	assign box_top      = top_q;
	assign box_right    = right_q;
	assign box_bottom   = bottom_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held for two cycles");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted transaction did not raise busy");

	a_box_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(box_left == NONE) == (box_top == NONE)) else $error("box edges disagree on empty");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !we) else $error("memory written while idle");

endmodule

// ----- tb/sv/tb_pixel_store_bbox_tracker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_store_bbox_tracker
// Drives pixel, channel, read and fill commands through the command port and
// checks each result against an in-bench model of the canvas, count and box.
// ----------------------------------------------------------------------------
module tb_pixel_store_bbox_tracker;

	localparam int MAXW = 256;
	localparam int MAXH = 256;
	localparam int WD_LIMIT = 400000;

	typedef struct packed {
		logic [7:0]  rr, rg, rb, ra;
		logic        modf, oor;
		logic [16:0] total;
		logic [8:0]  bl, bt, br, bb;
	} pix_result_t;

	typedef struct {
		logic [2:0]  fn;
		logic [15:0] px, py;
		logic [7:0]  r, g, b, a;
		logic        upd;
		logic        has_exp;
		pix_result_t exp_res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] func = '0;
	logic signed [15:0] x = '0, y = '0;
	logic [7:0] red = '0, green = '0, blue = '0, alpha = '0;
	logic update_bbox = 1'b0;
	logic done;
	logic [7:0] read_red, read_green, read_blue, read_alpha;
	logic modified, out_of_range;
	logic [16:0] opaque_total;
	logic signed [8:0] box_left, box_top, box_right, box_bottom;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	pixel_store_bbox_tracker dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// model state
	logic [31:0] canvas [MAXW*MAXH];
	logic [16:0] m_count;
	int m_l, m_t, m_r, m_b;
	logic [8:0] m_width, m_height;
	logic m_track, m_eblack;

	pix_result_t expected_q [$];
	pix_result_t pinned_q [$];
	logic pinned_has [$];
	int err_count = 0;
	int idle_cycles = 0;

	function automatic int cw();
		if (m_width < 1) return 1;
		if (m_width > MAXW) return MAXW;
		return m_width;
	endfunction

	function automatic int ch();
		if (m_height < 1) return 1;
		if (m_height > MAXH) return MAXH;
		return m_height;
	endfunction

	function automatic logic [7:0] alpha_of(int px, int py);
		if (px < 0 || py < 0 || px >= cw() || py >= ch()) return 8'd0;
		return canvas[py*cw()+px][31:24];
	endfunction

	function automatic void rescan();
		int sx, sy, ex, ey, fx, fy, l, t, r, b;
		bit found;
		sx = 0; sy = 0; ex = cw()-1; ey = ch()-1;
		fx = -1; fy = -1; l = -1; t = -1; r = -1; b = -1; found = 0;
		if (m_l != -1) begin
			sx = m_l; sy = m_t; ex = m_r; ey = m_b;
		end
		for (int i = sx; i <= ex; i++)
			for (int j = sy; j <= ey; j++)
				if (alpha_of(i, j) != 0) begin
					if (!found) begin
						found = 1; fx = i; fy = j; l = i; r = i; t = j; b = j;
					end else begin
						if (i < l) l = i;
						if (i > r) r = i;
						if (j < t) t = j;
						if (j > b) b = j;
					end
				end
		if (!found) begin
			m_l = -1; m_t = -1; m_r = -1; m_b = -1;
		end else if (m_count == 1) begin
			m_l = fx; m_t = fy; m_r = fx; m_b = fy;
		end else begin
			m_l = l; m_t = t; m_r = r; m_b = b;
		end
	endfunction

	function automatic pix_result_t predict_canvas(stim_row_t s);
		pix_result_t res;
		logic [31:0] colour, old, nw, rd;
		int px, py, w, h, idx;
		bit blank, upd, mod, oor;
		w = cw(); h = ch();
		px = $signed(s.px); py = $signed(s.py);
		colour = {s.a, s.b, s.g, s.r};
		rd = '0; mod = 0; oor = 0;
		if (s.fn == pst_pkg::FN_FILL) begin
			if (m_eblack && s.a == 0) colour = '0;
			for (int k = 0; k < w*h; k++)
				if (canvas[k] != colour) begin
					canvas[k] = colour; mod = 1;
				end
			if (s.a != 0) begin
				m_count = 17'(w*h);
				if (m_track) begin
					m_l = 0; m_t = 0; m_r = w-1; m_b = h-1;
				end
			end else begin
				m_count = 0;
				if (m_track) begin
					m_l = -1; m_t = -1; m_r = -1; m_b = -1;
				end
			end
		end else if (s.fn <= pst_pkg::FN_READ) begin
			if (px < 0 || py < 0 || px >= w || py >= h) begin
				oor = 1;
			end else begin
				idx = py*w + px;
				old = canvas[idx]; nw = old;
				blank = m_eblack && old[31:24] == 0;
				case (s.fn)
					pst_pkg::FN_PIXEL: nw = (m_eblack && s.a == 0) ? 32'd0 : colour;
					pst_pkg::FN_RED: nw[7:0] = blank ? 8'd0 : s.r;
					pst_pkg::FN_GREEN: nw[15:8] = blank ? 8'd0 : s.g;
					pst_pkg::FN_BLUE: nw[23:16] = blank ? 8'd0 : s.b;
					pst_pkg::FN_ALPHA:
						nw = (m_eblack && s.a == 0) ? 32'd0 : {s.a, old[23:0]};
					default: rd = old;
				endcase
				if (s.fn != pst_pkg::FN_READ && nw != old) begin
					upd = m_track && s.upd;
					canvas[idx] = nw;
					mod = 1;
					if (nw[31:24] == 0 && old[31:24] != 0) begin
						if (m_count > 0) m_count--;
						if (upd) rescan();
					end else if (nw[31:24] != 0 && old[31:24] == 0) begin
						if (m_count < pst_pkg::COUNT_LIMIT) m_count++;
						if (upd) begin
							if (m_l == -1) begin
								m_l = px; m_t = py; m_r = px; m_b = py;
							end else begin
								if (px < m_l) m_l = px; else if (px > m_r) m_r = px;
								if (py < m_t) m_t = py; else if (py > m_b) m_b = py;
							end
						end
					end
				end
			end
		end
		res.rr = rd[7:0]; res.rg = rd[15:8]; res.rb = rd[23:16]; res.ra = rd[31:24];
		res.modf = mod; res.oor = oor; res.total = m_count;
		res.bl = m_l[8:0]; res.bt = m_t[8:0]; res.br = m_r[8:0]; res.bb = m_b[8:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		err_count++;
	endtask

	// check results
	always @(posedge clk) begin
		pix_result_t e;
		if (arst_n && done) begin
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				e = expected_q.pop_front();
				if (pinned_has.pop_front() && pinned_q[0] != e)
					report_mismatch("table row vs model", 1, 0);
				void'(pinned_q.pop_front());
				if (read_red !== e.rr) report_mismatch("read_red", read_red, e.rr);
				if (read_green !== e.rg) report_mismatch("read_green", read_green, e.rg);
				if (read_blue !== e.rb) report_mismatch("read_blue", read_blue, e.rb);
				if (read_alpha !== e.ra) report_mismatch("read_alpha", read_alpha, e.ra);
				if (modified !== e.modf) report_mismatch("modified", modified, e.modf);
				if (out_of_range !== e.oor)
					report_mismatch("out_of_range", out_of_range, e.oor);
				if (opaque_total !== e.total)
					report_mismatch("opaque_total", opaque_total, e.total);
				if (box_left !== e.bl) report_mismatch("box_left", box_left, $signed(e.bl));
				if (box_top !== e.bt) report_mismatch("box_top", box_top, $signed(e.bt));
				if (box_right !== e.br)
					report_mismatch("box_right", box_right, $signed(e.br));
				if (box_bottom !== e.bb)
					report_mismatch("box_bottom", box_bottom, $signed(e.bb));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			pst_pkg::REG_WIDTH: m_width = val[8:0];
			pst_pkg::REG_HEIGHT: m_height = val[8:0];
			pst_pkg::REG_TRACK: m_track = val[0];
			default: m_eblack = val[0];
		endcase
	endtask

	task automatic drain();
		start <= 1'b0;
		while (expected_q.size() != 0 || busy) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send(stim_row_t s, bit gaps);
		if (gaps && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		start <= 1'b1;
		func <= s.fn; x <= s.px; y <= s.py;
		red <= s.r; green <= s.g; blue <= s.b; alpha <= s.a; update_bbox <= s.upd;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_q.push_back(predict_canvas(s));
		pinned_q.push_back(s.exp_res);
		pinned_has.push_back(s.has_exp);
	endtask

	function automatic stim_row_t row(logic [2:0] fn, int px, int py, logic [31:0] c,
			logic upd);
		stim_row_t s;
		s.fn = fn; s.px = px[15:0]; s.py = py[15:0];
		{s.a, s.b, s.g, s.r} = c;
		s.upd = upd; s.has_exp = 0; s.exp_res = '0;
		return s;
	endfunction

	function automatic stim_row_t pin(stim_row_t s, logic [31:0] rd, logic modf,
			logic oor, logic [16:0] total, int l, int t, int r, int b);
		s.has_exp = 1;
		s.exp_res = {rd[7:0], rd[15:8], rd[23:16], rd[31:24], modf, oor, total,
			l[8:0], t[8:0], r[8:0], b[8:0]};
		return s;
	endfunction

	function automatic stim_row_t rand_row(int w, int h);
		stim_row_t s;
		int px, py, sel;
		sel = $urandom_range(0, 99);
		px = $urandom_range(0, w-1); py = $urandom_range(0, h-1);
		if (sel < 8) px = $signed(16'($urandom));
		else if (sel < 12) py = $signed(16'($urandom));
		s = row(3'($urandom_range(0, 5)), px, py, $urandom, $urandom_range(0, 3) != 0);
		if ($urandom_range(0, 2) == 0) s.a = 0;
		if ($urandom_range(0, 60) == 0) s.fn = pst_pkg::FN_UNUSED;
		if ($urandom_range(0, 80) == 0) s.fn = pst_pkg::FN_FILL;
		return s;
	endfunction

	initial begin
		stim_row_t dir [$];
		int w, h;
		for (int k = 0; k < MAXW*MAXH; k++) canvas[k] = '0;
		m_count = 0; m_l = -1; m_t = -1; m_r = -1; m_b = -1;
		m_width = 256; m_height = 256; m_track = 1; m_eblack = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (busy) @(posedge clk);

		write_reg(pst_pkg::REG_WIDTH, 8);
		write_reg(pst_pkg::REG_HEIGHT, 6);
		dir.push_back(pin(row(pst_pkg::FN_READ, 0, 0, 0, 1), 0, 0, 0, 0, -1, -1, -1, -1));
		dir.push_back(pin(row(pst_pkg::FN_PIXEL, -32768, 0, 32'hFFFFFFFF, 1),
			0, 0, 1, 0, -1, -1, -1, -1));
		dir.push_back(pin(row(pst_pkg::FN_PIXEL, 0, 32767, 32'hFFFFFFFF, 1),
			0, 0, 1, 0, -1, -1, -1, -1));
		dir.push_back(pin(row(pst_pkg::FN_PIXEL, 7, 5, 32'hFFFFFFFF, 1),
			0, 1, 0, 1, 7, 5, 7, 5));
		dir.push_back(pin(row(pst_pkg::FN_READ, 7, 5, 0, 1),
			32'hFFFFFFFF, 0, 0, 1, 7, 5, 7, 5));
		dir.push_back(row(pst_pkg::FN_PIXEL, 0, 0, 32'h01020304, 1));
		dir.push_back(row(pst_pkg::FN_RED, 3, 3, 32'h000000AA, 1));
		dir.push_back(row(pst_pkg::FN_GREEN, 0, 0, 32'h0000BB00, 1));
		dir.push_back(row(pst_pkg::FN_BLUE, 0, 0, 32'h00CC0000, 1));
		dir.push_back(row(pst_pkg::FN_ALPHA, 3, 3, 32'h80000000, 1));
		dir.push_back(row(pst_pkg::FN_ALPHA, 7, 5, 32'h00000000, 1));
		dir.push_back(row(pst_pkg::FN_PIXEL, 0, 0, 32'h00FFFFFF, 1));
		dir.push_back(row(pst_pkg::FN_UNUSED, 0, 0, 32'hFFFFFFFF, 1));
		dir.push_back(row(pst_pkg::FN_READ, 0, 0, 0, 0));
		dir.push_back(row(pst_pkg::FN_FILL, -1, -1, 32'hFF000000, 1));
		dir.push_back(row(pst_pkg::FN_PIXEL, 2, 2, 0, 1));
		dir.push_back(row(pst_pkg::FN_FILL, 0, 0, 32'h00123456, 1));
		dir.push_back(pin(row(pst_pkg::FN_READ, -1, -1, 0, 1),
			0, 0, 1, 0, -1, -1, -1, -1));
		foreach (dir[i]) send(dir[i], 0);
		drain();

		write_reg(pst_pkg::REG_EBLACK, 1);
		write_reg(pst_pkg::REG_TRACK, 0);
		dir.delete();
		dir.push_back(row(pst_pkg::FN_RED, 1, 1, 32'h000000FF, 1));
		dir.push_back(row(pst_pkg::FN_PIXEL, 1, 1, 32'h11223300, 1));
		dir.push_back(row(pst_pkg::FN_PIXEL, 1, 1, 32'hFF223344, 1));
		dir.push_back(row(pst_pkg::FN_ALPHA, 1, 1, 32'h00000000, 1));
		dir.push_back(row(pst_pkg::FN_FILL, 0, 0, 32'h00ABCDEF, 0));
		foreach (dir[i]) send(dir[i], 0);
		drain();

		// random phases over several canvas settings, including the extremes
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin w = 1; h = 1; end
				1: begin w = 0; h = 300; end
				2: begin w = 16; h = 12; end
				3: begin w = 256; h = 4; end
				4: begin w = 9; h = 256; end
				default: begin w = 11; h = 7; end
			endcase
			write_reg(pst_pkg::REG_WIDTH, w);
			write_reg(pst_pkg::REG_HEIGHT, h);
			write_reg(pst_pkg::REG_TRACK, ph != 2);
			write_reg(pst_pkg::REG_EBLACK, ph[0]);
			w = cw(); h = ch();
			for (int n = 0; n < 100; n++) send(rand_row(w, h), ph < 5);
			drain();
		end

		if (err_count == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule
